>>> sv/pnip_pkg.sv
// Package for the palette nearest index pair core.
// Holds widths, Q0.16 weights, distance limit and shared types; no dependencies.
package pnip_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned NumEntry = 4;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned DistW    = 10;
  localparam int unsigned MinW     = 9;
  localparam int unsigned ProdW    = 27;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 16;

  // palette weights in Q0.16 (0.3 and 0.7); 0 and 1 need no multiply
  localparam logic signed [17:0] Weight1 = 18'sd19661;
  localparam logic signed [17:0] Weight2 = 18'sd45875;

  localparam logic [MinW-1:0] DistLimit = 9'h1FF;

  typedef logic [NumEntry-1:0][DistW-1:0] dist_arr_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            found;
    logic [MinW-1:0] min_dist;
  } sel_t;

endpackage

>>> sv/pnip_select.sv
// Nearest palette entry search over four distances for one sample.
// Depends on pnip_pkg.
module pnip_select (
  input  pnip_pkg::dist_arr_t dists,
  output pnip_pkg::sel_t      sel
);
  import pnip_pkg::*;

  always_comb begin
    sel.idx      = '0;
    sel.found    = 1'b0;
    sel.min_dist = DistLimit;
    for (int i = 0; i < NumEntry; i++) begin
      // strict compare: ties keep the lower index
      if (dists[i] < {1'b0, sel.min_dist}) begin
        sel.idx      = IdxW'(i);
        sel.found    = 1'b1;
        sel.min_dist = dists[i][MinW-1:0];
      end
    end
  end

endmodule

>>> sv/palette_nearest_index_pair_core.sv
// Top level: four-entry palette between two endpoints and nearest entry for two samples.
// Depends on pnip_pkg and pnip_select.
//
// channel  dir  tdata fields (low bit first)
// s_axis   in   end0 r,g,b; end1 r,g,b; sample_a r,g,b; sample_b r,g,b (8b each)
// m_axis   out  index_a[2], found_a, index_b[2], found_b, total_distance[10]
//
// Five register stages: weight multiply, palette, distances, search, total.
// One item per cycle while m_tready is not held low.
// Each stage takes new data when empty or when the next one moves, so bubbles fill under stall.
// rst clears the stage valid bits only.
module palette_nearest_index_pair_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // end0 r,g,b; end1 r,g,b; sample_a r,g,b; sample_b r,g,b
  input  logic [pnip_pkg::InDataW-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // index_a, found_a, index_b, found_b, total_distance
  output logic [pnip_pkg::OutDataW-1:0] m_tdata
);
  import pnip_pkg::*;

  typedef logic [NumChan-1:0][ChanW-1:0] rgb_t;
  typedef logic signed [ProdW-1:0] prod_t;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: endpoint delta times weight
  rgb_t in_e0, in_e1, in_sa, in_sb;
  prod_t [NumChan-1:0] in_p1, in_p2;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      logic signed [ChanW:0] d;
      in_e0[c] = s_tdata[ChanW*c +: ChanW];
      in_e1[c] = s_tdata[ChanW*(NumChan+c) +: ChanW];
      in_sa[c] = s_tdata[ChanW*(2*NumChan+c) +: ChanW];
      in_sb[c] = s_tdata[ChanW*(3*NumChan+c) +: ChanW];
      d = $signed({1'b0, in_e1[c]}) - $signed({1'b0, in_e0[c]});
      in_p1[c] = prod_t'(Weight1) * prod_t'(d);
      in_p2[c] = prod_t'(Weight2) * prod_t'(d);
    end
  end

  rgb_t e0_1, e1_1, sa_1, sb_1;
  prod_t [NumChan-1:0] p1_1, p2_1;

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      e0_1 <= in_e0;
      e1_1 <= in_e1;
      sa_1 <= in_sa;
      sb_1 <= in_sb;
      p1_1 <= in_p1;
      p2_1 <= in_p2;
    end
  end

  // stage 2: palette channels, floor of e0 + w*(e1-e0)
  rgb_t [NumEntry-1:0] pal_next;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod_t t1, t2;
      t1 = $signed({3'b000, e0_1[c], 16'h0000}) + p1_1[c];
      t2 = $signed({3'b000, e0_1[c], 16'h0000}) + p2_1[c];
      pal_next[0][c] = e0_1[c];
      pal_next[1][c] = t1[23:16];
      pal_next[2][c] = t2[23:16];
      pal_next[3][c] = e1_1[c];
    end
  end

  rgb_t [NumEntry-1:0] pal_2;
  rgb_t sa_2, sb_2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      pal_2 <= pal_next;
      sa_2  <= sa_1;
      sb_2  <= sb_1;
    end
  end

  // stage 3: sum of absolute channel differences
  dist_arr_t da_next, db_next;

  always_comb begin
    for (int i = 0; i < NumEntry; i++) begin
      da_next[i] = '0;
      db_next[i] = '0;
      for (int c = 0; c < NumChan; c++) begin
        logic [ChanW-1:0] xa, xb;
        xa = (sa_2[c] > pal_2[i][c]) ? sa_2[c] - pal_2[i][c] : pal_2[i][c] - sa_2[c];
        xb = (sb_2[c] > pal_2[i][c]) ? sb_2[c] - pal_2[i][c] : pal_2[i][c] - sb_2[c];
        da_next[i] = da_next[i] + DistW'(xa);
        db_next[i] = db_next[i] + DistW'(xb);
      end
    end
  end

  dist_arr_t da_3, db_3;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      da_3 <= da_next;
      db_3 <= db_next;
    end
  end

  // stage 4: nearest entry per sample
  sel_t sel_a_next, sel_b_next;

  pnip_select u_sel_a (
    .dists (da_3),
    .sel   (sel_a_next)
  );

  pnip_select u_sel_b (
    .dists (db_3),
    .sel   (sel_b_next)
  );

  sel_t sel_a_4, sel_b_4;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      sel_a_4 <= sel_a_next;
      sel_b_4 <= sel_b_next;
    end
  end

  // stage 5: total distance and output register
  logic [DistW-1:0] total_next;

  assign total_next = {1'b0, sel_a_4.min_dist} + {1'b0, sel_b_4.min_dist};

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      m_tdata <= {total_next, sel_b_4.found, sel_b_4.idx, sel_a_4.found, sel_a_4.idx};
    end
  end

endmodule

>>> sv/pnip_checker.sv
// Port-level checks for palette_nearest_index_pair_core, bound to the top level.
// Depends on pnip_pkg and palette_nearest_index_pair_core.
module pnip_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pnip_pkg::OutDataW-1:0] m_tdata
);
  import pnip_pkg::*;

  // no result leaves the core right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a not-found sample reports index 0
  a_idx_a: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[1:0] == 2'd0))
    else $error("index_a set without found_a");

  a_idx_b: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[5]) |-> (m_tdata[4:3] == 2'd0))
    else $error("index_b set without found_b");

  // neither found: both samples count the full limit
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2] && !m_tdata[5]) |-> (m_tdata[15:6] == 10'd1022))
    else $error("total distance wrong with no entry found");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind palette_nearest_index_pair_core pnip_checker u_pnip_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
